>>> design/aef_pkg.sv
package aef_pkg;

   // ENVELOPE instruction byte
   localparam logic [7:0] INS_ENVELOPE = 8'hC3;

   // Class bytes for chained and last fragments
   localparam logic [7:0] CLA_CHAINED = 8'h10;
   localparam logic [7:0] CLA_LAST    = 8'h00;

   // Register indexes on the csr port
   localparam logic [1:0] CSR_MAX_COMMAND  = 2'd0;
   localparam logic [1:0] CSR_MAX_RESPONSE = 2'd1;
   localparam logic [1:0] CSR_EXT_ALLOWED  = 2'd2;

   // Request opcodes
   localparam logic OP_BEGIN = 1'b0;
   localparam logic OP_DATA  = 1'b1;

   // Result status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_EXT   = 2'd1;
   localparam logic [1:0] ST_PROTOCOL = 2'd2;

   // Short form limits and the extended Le limit
   localparam logic [15:0] SHORT_LC_MAX = 16'd255;
   localparam logic [16:0] SHORT_LE_MAX = 17'd256;
   localparam logic [16:0] EXT_LE_MAX   = 17'd65536;

   // Queue between front and back
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef struct packed {
      logic       op;
      logic [15:0] msg_len;
      logic [7:0] data_byte;
   } aef_req_type;

   typedef struct packed {
      logic [7:0] apdu_byte;
      logic       apdu_end;
      logic       final_fragment;
      logic [1:0] status;
   } aef_rsp_type;

   typedef struct packed {
      logic [15:0] max_command_bytes;
      logic [16:0] max_response_bytes;
      logic        extended_allowed;
   } aef_cfg_type;

   // One classified item handed from front to back
   typedef struct packed {
      logic [1:0]  status;     // nonzero: single error result
      logic        header;     // emit command header ahead of the byte
      logic        ext;        // extended Lc / Le
      logic        fin;        // belongs to the final fragment
      logic        data_end;   // byte closes a chained fragment
      logic        trailer;    // Le follows the byte
      logic [15:0] frag;       // Lc value
      logic [7:0]  data;
      logic [15:0] le;         // Le value, 65536 coded as zero
   } aef_desc_type;

endpackage

>>> design/aef_front.sv
module aef_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  aef_pkg::aef_req_type  req_payload,
   input  aef_pkg::aef_cfg_type  cfg,
   input  logic                  q_full,
   output logic                  q_push,
   output aef_pkg::aef_desc_type q_data
);
   import aef_pkg::*;

   logic [15:0] remaining_ff, remaining_in;
   logic [15:0] frag_left_ff, frag_left_in;
   logic        frag_ext_ff, frag_ext_in;
   logic        frag_final_ff, frag_final_in;
   logic        open_ff, open_in;

   logic        accept;
   logic [15:0] eff_cmd;
   logic [16:0] eff_resp;
   logic        resp_long;
   logic [15:0] frag;
   logic        new_final;
   logic        new_ext;
   logic [15:0] cur_left;
   logic [15:0] next_left;
   logic        cur_final;
   logic        cur_ext;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   // Out of range registers clamp to legal values
   assign eff_cmd  = (cfg.max_command_bytes == 16'd0) ? 16'd1 : cfg.max_command_bytes;
   always_comb begin
      eff_resp = cfg.max_response_bytes;
      if (cfg.max_response_bytes == 17'd0) begin
         eff_resp = 17'd1;
      end else if (cfg.max_response_bytes > EXT_LE_MAX) begin
         eff_resp = EXT_LE_MAX;
      end
   end
   assign resp_long = eff_resp > SHORT_LE_MAX;

   // Fragment sizing for a fragment that starts with this byte
   assign frag      = (remaining_ff > eff_cmd) ? eff_cmd : remaining_ff;
   assign new_final = (remaining_ff <= eff_cmd);
   assign new_ext   = (frag > SHORT_LC_MAX) || (new_final && resp_long);

   assign cur_left  = (frag_left_ff == 16'd0) ? frag : frag_left_ff;
   assign cur_final = (frag_left_ff == 16'd0) ? new_final : frag_final_ff;
   assign cur_ext   = (frag_left_ff == 16'd0) ? new_ext : frag_ext_ff;
   assign next_left = cur_left - 16'd1;

   // Classify the request and update message state
   always_comb begin
      remaining_in  = remaining_ff;
      frag_left_in  = frag_left_ff;
      frag_ext_in   = frag_ext_ff;
      frag_final_in = frag_final_ff;
      open_in       = open_ff;
      q_push        = 1'b0;
      q_data        = '0;
      q_data.le     = eff_resp[15:0];
      q_data.data   = req_payload.data_byte;
      q_data.frag   = frag;
      if (accept) begin
         if (req_payload.op == OP_BEGIN) begin
            frag_left_in  = 16'd0;
            frag_ext_in   = 1'b0;
            frag_final_in = 1'b0;
            remaining_in  = req_payload.msg_len;
            open_in       = (req_payload.msg_len != 16'd0);
            if (req_payload.msg_len == 16'd0) begin
               q_push        = 1'b1;
               q_data.status = ST_PROTOCOL;
            end
         end else if (!open_ff || remaining_ff == 16'd0) begin
            // stray byte
            open_in       = 1'b0;
            q_push        = 1'b1;
            q_data.status = ST_PROTOCOL;
         end else if (frag_left_ff == 16'd0 && new_ext && !cfg.extended_allowed) begin
            // extended form needed but not allowed: abort the message
            open_in       = 1'b0;
            remaining_in  = 16'd0;
            frag_left_in  = 16'd0;
            frag_ext_in   = 1'b0;
            frag_final_in = 1'b0;
            q_push        = 1'b1;
            q_data.status = ST_NO_EXT;
         end else begin
            q_push          = 1'b1;
            q_data.header   = (frag_left_ff == 16'd0);
            q_data.ext      = cur_ext;
            q_data.fin      = cur_final;
            q_data.data_end = (next_left == 16'd0) && !cur_final;
            q_data.trailer  = (next_left == 16'd0) && cur_final;
            frag_left_in    = next_left;
            remaining_in    = remaining_ff - 16'd1;
            frag_ext_in     = cur_ext;
            frag_final_in   = cur_final;
            if (next_left == 16'd0 && cur_final) begin
               open_in       = 1'b0;
               remaining_in  = 16'd0;
               frag_ext_in   = 1'b0;
               frag_final_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff  <= '0;
         frag_left_ff  <= '0;
         frag_ext_ff   <= 1'b0;
         frag_final_ff <= 1'b0;
         open_ff       <= 1'b0;
      end else begin
         remaining_ff  <= remaining_in;
         frag_left_ff  <= frag_left_in;
         frag_ext_ff   <= frag_ext_in;
         frag_final_ff <= frag_final_in;
         open_ff       <= open_in;
      end
   end

   // A fragment in progress always belongs to an open message
   a_frag_open: assert property (@(posedge clock) disable iff (reset)
      frag_left_ff != 16'd0 |-> open_ff)
      else $error("fragment in progress without open message");

   // A fragment never runs past the end of the message
   a_frag_fits: assert property (@(posedge clock) disable iff (reset)
      frag_left_ff <= remaining_ff)
      else $error("fragment longer than remaining message");

   // Nothing is queued without an accepted request
   a_push_accept: assert property (@(posedge clock) disable iff (reset)
      q_push |-> accept)
      else $error("queue push without request transfer");

endmodule

>>> design/aef_queue.sv
module aef_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  aef_pkg::aef_desc_type push_data,
   input  logic                  pop,
   output logic                  full,
   output logic                  empty,
   output aef_pkg::aef_desc_type head
);
   import aef_pkg::*;

   aef_desc_type            slots_ff [QDEPTH];
   logic [QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]       count_ff, count_in;

   assign full  = (count_ff == QCNT_W'(QDEPTH));
   assign empty = (count_ff == '0);
   assign head  = slots_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from empty queue");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QDEPTH))
      else $error("queue count out of range");

endmodule

>>> design/aef_back.sv
module aef_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_empty,
   input  aef_pkg::aef_desc_type q_head,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output aef_pkg::aef_rsp_type  rsp_payload
);
   import aef_pkg::*;

   // Position within the bytes generated for one queued item
   typedef enum logic [9:0] {
      SLOT_CLA   = 10'b00_0000_0001,
      SLOT_INS   = 10'b00_0000_0010,
      SLOT_P1    = 10'b00_0000_0100,
      SLOT_P2    = 10'b00_0000_1000,
      SLOT_LC    = 10'b00_0001_0000,
      SLOT_LC_HI = 10'b00_0010_0000,
      SLOT_LC_LO = 10'b00_0100_0000,
      SLOT_DATA  = 10'b00_1000_0000,
      SLOT_LE_HI = 10'b01_0000_0000,
      SLOT_LE_LO = 10'b10_0000_0000
   } slot_type;

   slot_type    slot_ff, slot_in;
   slot_type    cur_slot;
   slot_type    next_slot;
   logic        rsp_valid_ff, rsp_valid_in;
   aef_rsp_type rsp_ff, rsp_in;
   aef_rsp_type gen;
   logic        is_last;
   logic        load;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Items without a header start directly at the data byte
   assign cur_slot = (slot_ff == SLOT_CLA && !q_head.header) ? SLOT_DATA : slot_ff;

   // Byte generation for the current slot
   always_comb begin
      gen                = '0;
      gen.final_fragment = q_head.fin;
      gen.status         = ST_OK;
      is_last            = 1'b0;
      next_slot          = SLOT_CLA;
      unique case (cur_slot)
         SLOT_CLA: begin
            gen.apdu_byte = q_head.fin ? CLA_LAST : CLA_CHAINED;
            next_slot     = SLOT_INS;
         end
         SLOT_INS: begin
            gen.apdu_byte = INS_ENVELOPE;
            next_slot     = SLOT_P1;
         end
         SLOT_P1: begin
            gen.apdu_byte = 8'h00;
            next_slot     = SLOT_P2;
         end
         SLOT_P2: begin
            gen.apdu_byte = 8'h00;
            next_slot     = SLOT_LC;
         end
         SLOT_LC: begin
            gen.apdu_byte = q_head.ext ? 8'h00 : q_head.frag[7:0];
            next_slot     = q_head.ext ? SLOT_LC_HI : SLOT_DATA;
         end
         SLOT_LC_HI: begin
            gen.apdu_byte = q_head.frag[15:8];
            next_slot     = SLOT_LC_LO;
         end
         SLOT_LC_LO: begin
            gen.apdu_byte = q_head.frag[7:0];
            next_slot     = SLOT_DATA;
         end
         SLOT_DATA: begin
            gen.apdu_byte = q_head.data;
            gen.apdu_end  = q_head.data_end;
            is_last       = !q_head.trailer;
            next_slot     = q_head.ext ? SLOT_LE_HI : SLOT_LE_LO;
         end
         SLOT_LE_HI: begin
            gen.apdu_byte = q_head.le[15:8];
            next_slot     = SLOT_LE_LO;
         end
         SLOT_LE_LO: begin
            gen.apdu_byte = q_head.le[7:0];
            gen.apdu_end  = 1'b1;
            is_last       = 1'b1;
         end
         default: begin
            gen.apdu_byte = 8'h00;
         end
      endcase
      // error items are a single all-zero result carrying the status
      if (q_head.status != ST_OK) begin
         gen        = '0;
         gen.status = q_head.status;
         is_last    = 1'b1;
      end
   end

   // Output register: refill whenever empty or its transfer completes
   assign load  = !q_empty && (!rsp_valid_ff || !rsp_stall);
   assign q_pop = load && is_last;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      slot_in      = slot_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_in       = gen;
         slot_in      = is_last ? SLOT_CLA : next_slot;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         slot_ff      <= SLOT_CLA;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         slot_ff      <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // A pending response is never overwritten while stalled
   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> !load)
      else $error("output register reloaded under stall");

   // Slot only leaves the start position while an item is at the head
   a_slot_idle: assert property (@(posedge clock) disable iff (reset)
      q_empty |-> slot_ff == SLOT_CLA)
      else $error("slot advanced with empty queue");

   // Error results never carry APDU framing
   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != ST_OK |-> !rsp_ff.apdu_end && !rsp_ff.final_fragment)
      else $error("error result with framing bits");

endmodule

>>> design/apdu_envelope_fragmenter.sv
// ENVELOPE command fragmenter. A begin request (op 0) opens a message of
// msg_len bytes; each data request (op 1) carries one message byte
// and yields that byte on rsp, preceded by a 5- or 7-byte command header
// (CLA, INS, P1, P2, Lc) when it starts a fragment and followed by a 1- or
// 2-byte Le when it ends the final fragment. Errors come out as a single
// result with a nonzero status. Requests are taken one per cycle into a
// 4-entry queue while it is not full; the response side emits one byte per
// cycle from a single output register while rsp_stall is low and the queue
// holds an item. The queue takes new requests while earlier items are still
// being sent. A request is written into the queue, then its first response
// byte is loaded into the output register. csr_ready is always high;
// registers should be written only while no message bytes are in flight.
module apdu_envelope_fragmenter (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  aef_pkg::aef_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output aef_pkg::aef_rsp_type rsp_payload,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [16:0]          csr_wdata
);
   import aef_pkg::*;

   aef_cfg_type  cfg_ff, cfg_in;
   logic         q_push;
   logic         q_pop;
   logic         q_full;
   logic         q_empty;
   aef_desc_type q_data;
   aef_desc_type q_head;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MAX_COMMAND:  cfg_in.max_command_bytes  = csr_wdata[15:0];
            CSR_MAX_RESPONSE: cfg_in.max_response_bytes = csr_wdata;
            CSR_EXT_ALLOWED:  cfg_in.extended_allowed   = csr_wdata[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_command_bytes  <= 16'd255;
         cfg_ff.max_response_bytes <= 17'd256;
         cfg_ff.extended_allowed   <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   aef_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .cfg         (cfg_ff),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_data      (q_data)
   );

   aef_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (q_head)
   );

   aef_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import aef_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   aef_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   aef_rsp_type rsp_payload;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [16:0] csr_wdata = '0;

   apdu_envelope_fragmenter dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   // 2 ns clock
   initial begin
      forever #1 clock = ~clock;
   end

   // Items waiting to go out, and APDU bytes the block still owes us
   aef_req_type envelope_requests[$];
   aef_rsp_type expected_apdu[$];

   int reqs_queued   = 0;
   int reqs_accepted = 0;
   int bytes_checked = 0;
   int mismatches    = 0;
   int phases        = 0;

   // Transfer flags seen at the last rising edge, used by the drivers at the falling edge
   bit req_fire = 1'b0;
   bit rsp_fire = 1'b0;

   // Idle control for both sides
   int req_hold   = 0;
   int rsp_hold   = 0;
   bit req_bursty = 1'b1;
   bit rsp_bursty = 1'b1;

   // Shadow of the block's registers
   logic [15:0] cfg_max_command;
   logic [16:0] cfg_max_response;
   logic        cfg_ext_allowed;

   // Fragmenter state as we expect it
   logic [15:0] msg_left;
   logic [15:0] frag_left;
   logic        frag_ext;
   logic        frag_final;
   logic        msg_open;

   function automatic void push_apdu(input logic [7:0] value, input logic last,
                                     input logic fin, input logic [1:0] st);
      aef_rsp_type r;
      r.apdu_byte      = value;
      r.apdu_end       = last;
      r.final_fragment = fin;
      r.status         = st;
      expected_apdu.push_back(r);
   endfunction

   function automatic void close_message();
      msg_open   = 1'b0;
      msg_left   = '0;
      frag_left  = '0;
      frag_ext   = 1'b0;
      frag_final = 1'b0;
   endfunction

   // Expected APDU bytes for one accepted request
   function automatic void predict_apdu(input aef_req_type item);
      logic [15:0] cmd_cap;
      logic [16:0] rsp_len;
      logic [15:0] frag;
      cmd_cap = (cfg_max_command == 0) ? 16'd1 : cfg_max_command;
      if (cfg_max_response == 0)
         rsp_len = 17'd1;
      else if (cfg_max_response > 17'd65536)
         rsp_len = 17'd65536;
      else
         rsp_len = cfg_max_response;

      // begin: drops whatever was open
      if (item.op == OP_BEGIN) begin
         frag_left  = '0;
         frag_ext   = 1'b0;
         frag_final = 1'b0;
         if (item.msg_len == 0) begin
            msg_open = 1'b0;
            msg_left = '0;
            push_apdu(8'h00, 1'b0, 1'b0, ST_PROTOCOL);
         end else begin
            msg_open = 1'b1;
            msg_left = item.msg_len;
         end
         return;
      end

      // byte with no message open
      if (!msg_open || msg_left == 0) begin
         msg_open = 1'b0;
         push_apdu(8'h00, 1'b0, 1'b0, ST_PROTOCOL);
         return;
      end

      // first byte of a fragment: header ahead of it
      if (frag_left == 0) begin
         frag       = (msg_left < cmd_cap) ? msg_left : cmd_cap;
         frag_final = (frag == msg_left);
         frag_ext   = (frag > 16'd255) || (frag_final && rsp_len > 17'd256);
         if (frag_ext && !cfg_ext_allowed) begin
            close_message();
            push_apdu(8'h00, 1'b0, 1'b0, ST_NO_EXT);
            return;
         end
         frag_left = frag;
         push_apdu(frag_final ? CLA_LAST : CLA_CHAINED, 1'b0, frag_final, ST_OK);
         push_apdu(INS_ENVELOPE, 1'b0, frag_final, ST_OK);
         push_apdu(8'h00, 1'b0, frag_final, ST_OK);
         push_apdu(8'h00, 1'b0, frag_final, ST_OK);
         if (frag_ext) begin
            push_apdu(8'h00, 1'b0, frag_final, ST_OK);
            push_apdu(frag[15:8], 1'b0, frag_final, ST_OK);
         end
         push_apdu(frag[7:0], 1'b0, frag_final, ST_OK);
      end

      frag_left = frag_left - 1'b1;
      msg_left  = msg_left - 1'b1;

      if (frag_left != 0) begin
         push_apdu(item.data_byte, 1'b0, frag_final, ST_OK);
      end else if (!frag_final) begin
         push_apdu(item.data_byte, 1'b1, 1'b0, ST_OK);
      end else begin
         // last byte of the message, then Le (65536 and 256 wrap to zero)
         push_apdu(item.data_byte, 1'b0, 1'b1, ST_OK);
         if (frag_ext)
            push_apdu(rsp_len[15:8], 1'b0, 1'b1, ST_OK);
         push_apdu(rsp_len[7:0], 1'b1, 1'b1, ST_OK);
         close_message();
      end
   endfunction

   function automatic void compare_field(input string name, input logic [7:0] want,
                                         input logic [7:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // Monitor: register writes, request transfers into the predictor, result check
   always @(posedge clock) begin : monitor
      aef_rsp_type want;
      req_fire = !reset && req_valid && !req_stall;
      rsp_fire = !reset && rsp_valid && !rsp_stall;
      if (reset) begin
         cfg_max_command  = 16'd255;
         cfg_max_response = 17'd256;
         cfg_ext_allowed  = 1'b0;
         close_message();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MAX_COMMAND:  cfg_max_command  = csr_wdata[15:0];
               CSR_MAX_RESPONSE: cfg_max_response = csr_wdata;
               CSR_EXT_ALLOWED:  cfg_ext_allowed  = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_fire) begin
            predict_apdu(req_payload);
            reqs_accepted++;
         end
         if (rsp_fire) begin
            if (expected_apdu.size() == 0) begin
               $display("%0t ns: unexpected result, expected none, actual %p",
                        $time, rsp_payload);
               mismatches++;
            end else begin
               want = expected_apdu.pop_front();
               compare_field("apdu_byte", want.apdu_byte, rsp_payload.apdu_byte);
               compare_field("apdu_end", 8'(want.apdu_end), 8'(rsp_payload.apdu_end));
               compare_field("final_fragment", 8'(want.final_fragment),
                             8'(rsp_payload.final_fragment));
               compare_field("status", 8'(want.status), 8'(rsp_payload.status));
            end
            bytes_checked++;
         end
      end
   end

   // Request driver: holds a stalled item, idles a drawn number of cycles after each transfer
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_fire) begin
            if (req_hold > 0) begin
               req_valid <= 1'b0;
               req_hold--;
            end else if (envelope_requests.size() != 0) begin
               req_payload <= envelope_requests.pop_front();
               req_valid   <= 1'b1;
               if ($urandom_range(0, 31) == 0)
                  req_bursty = !req_bursty;
               req_hold = req_bursty ? $urandom_range(0, 11) : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result side: stalls a drawn number of cycles after each transfer
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_fire) begin
            if ($urandom_range(0, 31) == 0)
               rsp_bursty = !rsp_bursty;
            rsp_hold = rsp_bursty ? $urandom_range(0, 11) : 0;
         end
         if (rsp_hold > 0) begin
            rsp_stall <= 1'b1;
            rsp_hold--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic void queue_item(input logic op, input logic [15:0] len,
                                      input logic [7:0] value);
      aef_req_type item;
      item.op        = op;
      item.msg_len   = len;
      item.data_byte = value;
      envelope_requests.push_back(item);
      reqs_queued++;
   endfunction

   // Begin of len bytes followed by count data items; unused fields carry noise
   function automatic void queue_message(input int len, input int count);
      queue_item(OP_BEGIN, len[15:0], 8'($urandom));
      for (int i = 0; i < count; i++)
         queue_item(OP_DATA, 16'($urandom), 8'($urandom));
   endfunction

   // Mostly whole messages, some stray bytes, zero lengths and cut-off messages
   function automatic void queue_random_traffic(input int count);
      int added, kind, len, sent;
      added = 0;
      while (added < count) begin
         kind = $urandom_range(0, 19);
         if (kind == 0) begin
            queue_item(OP_DATA, 16'($urandom), 8'($urandom));
            added++;
         end else if (kind == 1) begin
            queue_item(OP_BEGIN, 16'h0000, 8'($urandom));
            added++;
         end else if (kind == 2) begin
            len  = $urandom_range(1, 65535);
            sent = $urandom_range(0, 4);
            queue_message(len, sent);
            added += sent + 1;
         end else begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            queue_message(len, len);
            added += len + 1;
         end
      end
   endfunction

   // Wait until every item went out and every result came back, plus a hold-off
   task automatic wait_drained();
      while (reqs_accepted != reqs_queued || expected_apdu.size() != 0)
         @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [16:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_config(input logic [15:0] cmd, input logic [16:0] rsp, input logic ext);
      wait_drained();
      write_register(CSR_MAX_COMMAND, {1'b0, cmd});
      write_register(CSR_MAX_RESPONSE, rsp);
      write_register(CSR_EXT_ALLOWED, {16'd0, ext});
      @(negedge clock);
      csr_valid <= 1'b0;
      phases++;
   endtask

   // Stimulus
   initial begin
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // reset settings: stray byte, zero length, dropped messages, short APDU
      queue_item(OP_DATA, 16'h0000, 8'h5A);
      queue_item(OP_BEGIN, 16'h0000, 8'h00);
      queue_item(OP_BEGIN, 16'hFFFF, 8'hFF);
      queue_item(OP_BEGIN, 16'd3, 8'h00);
      queue_item(OP_DATA, 16'hFFFF, 8'h00);
      queue_item(OP_DATA, 16'h0000, 8'hFF);
      queue_item(OP_DATA, 16'h1234, 8'hA5);
      queue_item(OP_DATA, 16'h0000, 8'h11);
      queue_item(OP_BEGIN, 16'd2, 8'h00);
      queue_item(OP_DATA, 16'h0000, 8'h3C);
      queue_item(OP_BEGIN, 16'd1, 8'h00);
      queue_item(OP_DATA, 16'h0000, 8'hC3);

      // one byte per fragment, Le of one
      set_config(16'd1, 17'd1, 1'b0);
      queue_message(3, 3);
      queue_random_traffic(12);

      // extended Lc/Le on the last fragment, Le of 65536 coded as zero
      set_config(16'd4, 17'd65536, 1'b1);
      queue_message(6, 6);
      queue_random_traffic(12);

      // same, extended refused: error at the last fragment, rest are strays
      set_config(16'd4, 17'd65536, 1'b0);
      queue_message(6, 6);
      queue_random_traffic(12);

      // zero registers act as one
      set_config(16'd0, 17'd0, 1'b1);
      queue_random_traffic(12);

      // largest register values, response size clamped
      set_config(16'hFFFF, 17'h1FFFF, 1'b1);
      queue_random_traffic(12);

      // fragment over 255 bytes forces extended Lc
      set_config(16'd256, 17'd257, 1'b1);
      queue_message(258, 258);
      queue_random_traffic(5);

      // same fragment with extended refused, then a few strays
      set_config(16'd300, 17'd200, 1'b0);
      queue_message(256, 4);
      queue_random_traffic(12);

      // random settings
      for (int p = 0; p < 4; p++) begin
         set_config(16'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 16)),
                    17'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 300) : $urandom),
                    1'($urandom));
         queue_random_traffic(14);
      end

      wait_drained();
      $display("Sent %0d requests over %0d register settings, checked %0d APDU bytes.",
               reqs_accepted, phases + 1, bytes_checked);
      if (mismatches == 0) begin
         $display("[apdu_envelope_fragmenter] OK");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("[apdu_envelope_fragmenter] ERROR");
      end
      $finish;
   end

   // Run time limit
   initial begin
      #2000000;
      $display("Timed out with %0d results outstanding", expected_apdu.size());
      $display("[apdu_envelope_fragmenter] ERROR");
      $finish;
   end

endmodule
